/* design/crsf_pkg.sv */
package crsf_pkg;
   localparam int MaxRows      = 1024;
   localparam int MaxEntries   = 4096;
   localparam int IdBits       = 16;
   localparam int FracBits     = 16;
   localparam int RowAw        = $clog2(MaxRows + 1);
   localparam int EntAw        = $clog2(MaxEntries);
   localparam int OffW         = $clog2(MaxEntries + 1);
   localparam int CntW         = 32;
   localparam int TotW         = 44;
   localparam int FracW        = FracBits + 1;
   localparam int NumW         = CntW + FracBits;

   typedef enum logic [1:0] {
      OP_LOAD_OFFSET = 2'd0,
      OP_LOAD_ENTRY  = 2'd1,
      OP_QUERY       = 2'd2,
      OP_NONE        = 2'd3
   } op_type;

   typedef struct packed {
      logic            start;
      logic [NumW-1:0] numer;
      logic [TotW-1:0] denom;
   } div_req_type;
endpackage

/* design/crsf_divider.sv */
module crsf_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  crsf_pkg::div_req_type     div_req,
   output logic                      div_done,
   output logic [crsf_pkg::FracW-1:0] div_quot
);
   import crsf_pkg::*;

   localparam int StepW = $clog2(NumW + 1);

   logic [NumW-1:0]  num_ff, num_in;
   logic [TotW:0]    rem_ff, rem_in;
   logic [TotW-1:0]  den_ff, den_in;
   logic [StepW-1:0] step_ff, step_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [TotW:0]    trial;

   // restoring division, one quotient bit per cycle; quotient shifts into num
   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[TotW-1:0], num_ff[NumW-1]};
      if (div_req.start) begin
         num_in  = div_req.numer;
         den_in  = div_req.denom;
         rem_in  = '0;
         step_in = StepW'(NumW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            num_in = {num_ff[NumW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            num_in = {num_ff[NumW-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == StepW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_done = done_ff;
   assign div_quot = num_ff[FracW-1:0];

   property p_done_after_busy;
      @(posedge clock) disable iff (reset) div_done |-> $past(busy_ff);
   endproperty
   a_done_after_busy: assert property (p_done_after_busy)
      else $error("divider done without work");
endmodule

/* design/csr_row_search_fraction.sv */
// Loads and unused ops: the FSM passes through S_DONE, then rsp_valid strobes.
// Query: read the row bounds, binary search (up to 13 probes), sum every row
//   entry, read the matched count on a hit, run the divider when the total is
//   nonzero, then S_DONE presents. Divider is bit-serial, 48 bits.
// One beat at a time; busy is high until the strobe; the receiver cannot stall.
// Synchronous active-high reset clears control state; memories are not cleared.
module csr_row_search_fraction (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [1:0]   req_op,
   input  logic         req_table_select,
   input  logic [10:0]  req_edge_index,
   input  logic [12:0]  req_offset_value,
   input  logic [11:0]  req_entry_index,
   input  logic [15:0]  req_gene_id,
   input  logic [31:0]  req_gene_count,
   output logic         rsp_valid,
   output logic         rsp_found,
   output logic [16:0]  rsp_fraction,
   output logic [31:0]  rsp_matched_count,
   output logic [43:0]  rsp_row_total
);
   import crsf_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_OFF_LO, S_OFF_HI, S_CHECK, S_PROBE, S_PROBE_CMP,
      S_SUM, S_SUM_LAST, S_HITCNT, S_HITCNT_WAIT, S_DIV, S_DONE
   } state_type;

   // memories: table select is the top address bit
   logic [OffW-1:0]   off_mem [2**(RowAw+1)];
   logic [IdBits-1:0] id_mem  [2*MaxEntries];
   logic [CntW-1:0]   cnt_mem [2*MaxEntries];

   logic [OffW-1:0]   off_rd_ff;
   logic [IdBits-1:0] id_rd_ff;
   logic [CntW-1:0]   cnt_rd_ff;
   logic [RowAw:0]    off_addr;
   logic [EntAw:0]    id_addr, cnt_addr;
   logic              off_we, ent_we;
   logic [OffW-1:0]   off_wdata;

   state_type         state_ff;
   logic              sel_ff;
   logic [IdBits-1:0] gid_ff;
   logic [RowAw-1:0]  row_ff;
   logic [OffW-1:0]   lo_ff, hi_ff, a_ff, b_ff, mid_ff, idx_ff, hitpos_ff;
   logic              hit_ff;
   logic [TotW-1:0]   total_ff;
   logic [CntW-1:0]   mcnt_ff;
   logic              valid_ff, found_ff;
   logic [FracW-1:0]  frac_ff;
   logic [OffW-1:0]   mid_calc;
   op_type            op;
   div_req_type       div_req;
   logic              div_done;
   logic [FracW-1:0]  div_quot;

   assign op        = op_type'(req_op);
   assign off_we    = start && !busy && op == OP_LOAD_OFFSET
                      && {1'b0, req_edge_index} <= 12'(MaxRows);
   assign ent_we    = start && !busy && op == OP_LOAD_ENTRY;
   assign off_wdata = (req_offset_value > 13'(MaxEntries)) ? OffW'(MaxEntries)
                                                           : req_offset_value;
   assign mid_calc  = a_ff + ((b_ff - a_ff) >> 1);

   // read addresses: row start in S_OFF_LO, row end in S_OFF_HI
   always_comb begin
      off_addr = {sel_ff, row_ff};
      if (state_ff == S_OFF_HI) off_addr = {sel_ff, row_ff + 1'b1};
      id_addr  = {sel_ff, mid_calc[EntAw-1:0]};
      cnt_addr = {sel_ff, idx_ff[EntAw-1:0]};
      if (state_ff == S_HITCNT) cnt_addr = {sel_ff, hitpos_ff[EntAw-1:0]};
   end

   always_ff @(posedge clock) begin
      if (off_we) off_mem[{req_table_select, req_edge_index[RowAw-1:0]}] <= off_wdata;
      off_rd_ff <= off_mem[off_addr];
   end

   always_ff @(posedge clock) begin
      if (ent_we) id_mem[{req_table_select, req_entry_index}] <= req_gene_id;
      id_rd_ff <= id_mem[id_addr];
   end

   always_ff @(posedge clock) begin
      if (ent_we) cnt_mem[{req_table_select, req_entry_index}] <= req_gene_count;
      cnt_rd_ff <= cnt_mem[cnt_addr];
   end

   assign div_req.start = (state_ff == S_HITCNT_WAIT) && total_ff != '0;
   assign div_req.numer = {cnt_rd_ff, FracBits'(0)};
   assign div_req.denom = total_ff;

   crsf_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_quot (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  sel_ff   <= req_table_select;
                  gid_ff   <= req_gene_id;
                  row_ff   <= req_edge_index[RowAw-1:0];
                  found_ff <= 1'b0;
                  frac_ff  <= '0;
                  mcnt_ff  <= '0;
                  total_ff <= '0;
                  hit_ff   <= 1'b0;
                  if (op == OP_QUERY && {1'b0, req_edge_index} < 12'(MaxRows))
                     state_ff <= S_OFF_LO;
                  else
                     state_ff <= S_DONE;
               end
            end
            S_OFF_LO: state_ff <= S_OFF_HI;   // row start read issued
            S_OFF_HI: begin
               lo_ff    <= off_rd_ff;
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               hi_ff <= off_rd_ff;
               a_ff  <= lo_ff;
               b_ff  <= off_rd_ff;
               idx_ff <= lo_ff;
               if (lo_ff >= off_rd_ff) state_ff <= S_DONE;
               else                    state_ff <= S_PROBE;
            end
            S_PROBE: begin
               // id read at mid issued this cycle
               mid_ff   <= mid_calc;
               state_ff <= S_PROBE_CMP;
            end
            S_PROBE_CMP: begin
               priority if (id_rd_ff == gid_ff) begin
                  hit_ff    <= 1'b1;
                  hitpos_ff <= mid_ff;
                  state_ff  <= S_SUM;
               end else if (id_rd_ff < gid_ff) begin
                  a_ff     <= mid_ff + 1'b1;
                  state_ff <= (mid_ff + 1'b1 < b_ff) ? S_PROBE : S_SUM;
               end else begin
                  b_ff     <= mid_ff;
                  state_ff <= (a_ff < mid_ff) ? S_PROBE : S_SUM;
               end
            end
            S_SUM: begin
               // count read at idx issued; accumulate previous read
               if (idx_ff != lo_ff) total_ff <= total_ff + TotW'(cnt_rd_ff);
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff + 1'b1 == hi_ff) state_ff <= S_SUM_LAST;
            end
            S_SUM_LAST: begin
               total_ff <= total_ff + TotW'(cnt_rd_ff);
               state_ff <= hit_ff ? S_HITCNT : S_DONE;
            end
            S_HITCNT: state_ff <= S_HITCNT_WAIT;
            S_HITCNT_WAIT: begin
               found_ff <= 1'b1;
               mcnt_ff  <= cnt_rd_ff;
               state_ff <= (total_ff != '0) ? S_DIV : S_DONE;
            end
            S_DIV: begin
               if (div_done) begin
                  frac_ff  <= div_quot;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy              = state_ff != S_IDLE;
   assign rsp_valid         = valid_ff;
   assign rsp_found         = found_ff;
   assign rsp_fraction      = frac_ff;
   assign rsp_matched_count = mcnt_ff;
   assign rsp_row_total     = total_ff;

   property p_result_after_done;
      @(posedge clock) disable iff (reset) rsp_valid |-> $past(state_ff == S_DONE);
   endproperty
   a_result_after_done: assert property (p_result_after_done)
      else $error("result without done state");

   property p_no_found_without_hit;
      @(posedge clock) disable iff (reset) (rsp_valid && rsp_found) |-> hit_ff;
   endproperty
   a_no_found_without_hit: assert property (p_no_found_without_hit)
      else $error("found without search hit");

   property p_frac_bound;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> (rsp_fraction == '0 || rsp_found);
   endproperty
   a_frac_bound: assert property (p_frac_bound)
      else $error("fraction nonzero without hit");
endmodule
